FILE: rtl/fcct_pkg.sv
package fcct_pkg;

  // Widths fixed by the beat format
  localparam int CNT_W = 16;
  localparam int ID_W  = 3;
  localparam int CMD_W = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CMD_W-1:0] cmd_t;

  // Command codes
  localparam cmd_t CMD_TICK       = 3'd0;
  localparam cmd_t CMD_START_ONE  = 3'd1;
  localparam cmd_t CMD_START_PER  = 3'd2;
  localparam cmd_t CMD_CHANGE     = 3'd3;
  localparam cmd_t CMD_STOP       = 3'd4;
  localparam cmd_t CMD_MARK_BYP   = 3'd5;
  localparam cmd_t CMD_POLL       = 3'd6;
  localparam cmd_t CMD_UNUSED     = 3'd7;

  typedef struct packed {
    cmd_t command;
    id_t  channel_id;
    cnt_t delay_ticks;
  } in_beat_t;

  typedef struct packed {
    cnt_t count_value;
    id_t  assigned_id;
    id_t  fired_channel;
    logic bypass_event;
    id_t  pending_channel;
    logic last_result;
  } out_beat_t;

endpackage

FILE: rtl/fcct_in_reg.sv
module fcct_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fcct_pkg::in_beat_t in_beat,
  output logic               in_stall,
  input  logic               take,
  output logic               valid_q,
  output fcct_pkg::in_beat_t beat_q
);

  logic               valid_r;
  logic               valid_nxt;
  fcct_pkg::in_beat_t beat_r;

  // Hold the input stage while its beat waits for the core
  assign in_stall  = valid_r && !take;
  assign valid_nxt = (in_valid && !in_stall) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat_r <= in_beat;
    end
  end

  assign valid_q = valid_r;
  assign beat_q  = beat_r;

endmodule

FILE: rtl/fcct_core.sv
module fcct_core #(
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  fcct_pkg::cnt_t      cfg_data,
  input  logic                in_valid,
  input  fcct_pkg::in_beat_t  in_beat,
  input  logic                out_ready,
  output logic                take,
  output logic                emit,
  output fcct_pkg::out_beat_t res
);

  fcct_pkg::cnt_t div_r;
  fcct_pkg::cnt_t cnt_r, cnt_nxt;
  fcct_pkg::cnt_t pre_r, pre_nxt;
  fcct_pkg::cnt_t cmp_r [CHANNELS];
  fcct_pkg::cnt_t cmp_nxt [CHANNELS];
  fcct_pkg::cnt_t per_r [CHANNELS];
  fcct_pkg::cnt_t per_nxt [CHANNELS];
  logic [CHANNELS-1:0] en_r, en_nxt;
  logic [CHANNELS-1:0] match_r, match_nxt;
  logic [CHANNELS-1:0] perm_r, perm_nxt;
  logic [CHANNELS-1:0] byp_r, byp_nxt;
  logic [CHANNELS-1:0] pend_r, pend_nxt;
  logic [CHANNELS-1:0] drain_r, drain_nxt;

  logic                drain_step;
  logic [CHANNELS-1:0] sel;
  logic [CHANNELS-1:0] ready_mask;
  logic [CHANNELS-1:0] poll_mask;
  logic                found;
  fcct_pkg::cnt_t      sum_delay;

  // A poll with several pending channels drains one beat per cycle while the output register is ready
  assign take       = in_valid && out_ready && (drain_r == '0);
  assign drain_step = (drain_r != '0) && out_ready;
  assign emit       = take || drain_step;
  assign sum_delay  = cnt_r + in_beat.delay_ticks;

  // Channel selected by the channel id, none for an id out of range
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      sel[i] = (int'(in_beat.channel_id) == i + 1);
    end
  end

  // Next state and result for one beat
  always_comb begin
    cnt_nxt    = cnt_r;
    pre_nxt    = pre_r;
    cmp_nxt    = cmp_r;
    per_nxt    = per_r;
    en_nxt     = en_r;
    match_nxt  = match_r;
    perm_nxt   = perm_r;
    byp_nxt    = byp_r;
    pend_nxt   = pend_r;
    drain_nxt  = drain_r;
    ready_mask = '0;
    poll_mask  = '0;
    found      = 1'b0;
    res        = '0;
    res.count_value = cnt_r;
    res.last_result = 1'b1;

    if (drain_r != '0 || in_beat.command == fcct_pkg::CMD_POLL) begin
      // Report the lowest pending channel; the rest follow in later beats
      poll_mask = (drain_r != '0) ? drain_r : pend_r;
      if (drain_r == '0) begin
        pend_nxt = '0;
      end
      drain_nxt = poll_mask;
      for (int i = 0; i < CHANNELS; i++) begin
        if (poll_mask[i] && !found) begin
          found = 1'b1;
          drain_nxt[i] = 1'b0;
          res.pending_channel = fcct_pkg::id_t'(i + 1);
        end
      end
      res.last_result = (drain_nxt == '0);
    end else begin
      unique case (in_beat.command)
        fcct_pkg::CMD_TICK: begin
          if (pre_r >= div_r) begin
            pre_nxt = '0;
            cnt_nxt = cnt_r + 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
              if (en_r[i] && cmp_r[i] == cnt_nxt) begin
                match_nxt[i] = 1'b1;
              end
            end
          end else begin
            pre_nxt = pre_r + 1'b1;
          end
          res.count_value = cnt_nxt;
          ready_mask = match_nxt & en_r;
          for (int i = 0; i < CHANNELS; i++) begin
            if (ready_mask[i] && !found) begin
              found = 1'b1;
              match_nxt[i] = 1'b0;
              if (perm_r[i]) begin
                cmp_nxt[i] = cmp_r[i] + per_r[i];
              end else begin
                en_nxt[i] = 1'b0;
              end
              res.bypass_event  = byp_r[i];
              pend_nxt[i]       = 1'b1;
              res.fired_channel = fcct_pkg::id_t'(i + 1);
            end
          end
        end
        fcct_pkg::CMD_START_ONE, fcct_pkg::CMD_START_PER: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (!en_r[i] && !found) begin
              found = 1'b1;
              pend_nxt[i]  = 1'b0;
              byp_nxt[i]   = 1'b0;
              match_nxt[i] = 1'b0;
              perm_nxt[i]  = (in_beat.command == fcct_pkg::CMD_START_PER);
              if (in_beat.command == fcct_pkg::CMD_START_PER) begin
                per_nxt[i] = in_beat.delay_ticks;
              end
              cmp_nxt[i] = sum_delay;
              en_nxt[i]  = 1'b1;
              res.assigned_id = fcct_pkg::id_t'(i + 1);
            end
          end
        end
        fcct_pkg::CMD_CHANGE: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (sel[i]) begin
              cmp_nxt[i] = sum_delay;
            end
          end
        end
        fcct_pkg::CMD_STOP: begin
          en_nxt    = en_r & ~sel;
          match_nxt = match_r & ~sel;
          pend_nxt  = pend_r & ~sel;
          perm_nxt  = perm_r & ~sel;
          byp_nxt   = byp_r & ~sel;
        end
        fcct_pkg::CMD_MARK_BYP: begin
          byp_nxt = byp_r | sel;
        end
        default: begin
        end
      endcase
    end
  end

  // Prescale divisor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else if (cfg_we) begin
      div_r <= cfg_data;
    end
  end

  // Timer and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pre_r   <= '0;
      en_r    <= '0;
      match_r <= '0;
      perm_r  <= '0;
      byp_r   <= '0;
      pend_r  <= '0;
      drain_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_r[i] <= '0;
        per_r[i] <= '0;
      end
    end else if (emit) begin
      cnt_r   <= cnt_nxt;
      pre_r   <= pre_nxt;
      en_r    <= en_nxt;
      match_r <= match_nxt;
      perm_r  <= perm_nxt;
      byp_r   <= byp_nxt;
      pend_r  <= pend_nxt;
      drain_r <= drain_nxt;
      cmp_r   <= cmp_nxt;
      per_r   <= per_nxt;
    end
  end

endmodule

FILE: rtl/fcct_out_reg.sv
module fcct_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  fcct_pkg::out_beat_t beat,
  output logic                ready,
  output logic                out_valid,
  output fcct_pkg::out_beat_t out_beat,
  input  logic                out_stall
);

  logic                valid_r;
  fcct_pkg::out_beat_t beat_r;

  // Free when empty or when the held beat leaves this cycle
  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      beat_r <= beat;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/four_channel_compare_timer_scheduler.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_beat  (command, channel_id, delay_ticks)
// out      output     out_valid / out_stall  out_beat (count, ids, events, last_result)
// cfg      input      cfg_we                 cfg_data (prescale divisor)
//
// An accepted beat is held in the input register, processed combinationally in the
// core and its result is held in the output register.
// One beat is taken per cycle while the output is not stalled; a poll that finds n
// pending channels issues n beats, one per cycle, holding the input until the last.
// Synchronous reset clears the counter, prescaler, all channel state and the divisor.
// A stall on the output backs up through the core to in_stall without losing beats.
module four_channel_compare_timer_scheduler #(
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  fcct_pkg::cnt_t      cfg_data,
  input  logic                in_valid,
  input  fcct_pkg::in_beat_t  in_beat,
  output logic                in_stall,
  output logic                out_valid,
  output fcct_pkg::out_beat_t out_beat,
  input  logic                out_stall
);

  logic                take;
  logic                emit;
  logic                out_ready;
  logic                core_valid;
  fcct_pkg::in_beat_t  core_beat;
  fcct_pkg::out_beat_t res;

  fcct_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .in_stall (in_stall),
    .take     (take),
    .valid_q  (core_valid),
    .beat_q   (core_beat)
  );

  fcct_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (core_valid),
    .in_beat   (core_beat),
    .out_ready (out_ready),
    .take      (take),
    .emit      (emit),
    .res       (res)
  );

  fcct_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .beat      (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .out_stall (out_stall)
  );

endmodule

FILE: verif/four_channel_compare_timer_scheduler_tb.sv
module four_channel_compare_timer_scheduler_tb;

  localparam int NUM_CH = 4;
  localparam int HOLD_CYCLES = 150;

  // Tracks the timer state and the result beats that are still due.
  class timer_tracker;
    fcct_pkg::cnt_t divisor;
    fcct_pkg::cnt_t counter;
    fcct_pkg::cnt_t prescale;
    fcct_pkg::cnt_t compare_val [NUM_CH];
    fcct_pkg::cnt_t period_val [NUM_CH];
    logic [NUM_CH-1:0] enabled;
    logic [NUM_CH-1:0] matched;
    logic [NUM_CH-1:0] periodic;
    logic [NUM_CH-1:0] bypass;
    logic [NUM_CH-1:0] pending;
    fcct_pkg::out_beat_t due_results [$];
    int errors;

    function new();
      divisor = '0;
      counter = '0;
      prescale = '0;
      foreach (compare_val[i]) begin
        compare_val[i] = '0;
        period_val[i] = '0;
      end
      enabled = '0;
      matched = '0;
      periodic = '0;
      bypass = '0;
      pending = '0;
      errors = 0;
    endfunction

    function void set_divisor(fcct_pkg::cnt_t value);
      divisor = value;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void add_due(fcct_pkg::cnt_t cnt, fcct_pkg::id_t asg, fcct_pkg::id_t fired,
                          logic byp, fcct_pkg::id_t pend, logic last);
      fcct_pkg::out_beat_t r;
      r.count_value = cnt;
      r.assigned_id = asg;
      r.fired_channel = fired;
      r.bypass_event = byp;
      r.pending_channel = pend;
      r.last_result = last;
      due_results.push_back(r);
    endfunction

    // Advance the prescaler and counter, then service the lowest ready channel.
    function void run_tick();
      fcct_pkg::id_t fired;
      logic byp;
      logic [NUM_CH-1:0] ready;
      fired = '0;
      byp = 1'b0;
      if (prescale >= divisor) begin
        prescale = '0;
        counter = counter + 1'b1;
        for (int i = 0; i < NUM_CH; i++)
          if (enabled[i] && compare_val[i] == counter) matched[i] = 1'b1;
      end else begin
        prescale = prescale + 1'b1;
      end
      ready = matched & enabled;
      for (int i = 0; i < NUM_CH; i++) begin
        if (ready[i] && fired == '0) begin
          matched[i] = 1'b0;
          if (periodic[i]) compare_val[i] = compare_val[i] + period_val[i];
          else enabled[i] = 1'b0;
          byp = bypass[i];
          pending[i] = 1'b1;
          fired = fcct_pkg::id_t'(i + 1);
        end
      end
      add_due(counter, '0, fired, byp, '0, 1'b1);
    endfunction

    // A start takes the lowest channel that is not enabled.
    function fcct_pkg::id_t start_channel(fcct_pkg::cnt_t delay, logic per);
      for (int i = 0; i < NUM_CH; i++) begin
        if (!enabled[i]) begin
          pending[i] = 1'b0;
          periodic[i] = per;
          bypass[i] = 1'b0;
          matched[i] = 1'b0;
          if (per) period_val[i] = delay;
          compare_val[i] = counter + delay;
          enabled[i] = 1'b1;
          return fcct_pkg::id_t'(i + 1);
        end
      end
      return '0;
    endfunction

    function void take_command(fcct_pkg::in_beat_t b);
      logic ok;
      int ch;
      ok = (b.channel_id >= 1 && b.channel_id <= NUM_CH);
      ch = ok ? int'(b.channel_id) - 1 : 0;
      case (b.command)
        fcct_pkg::CMD_TICK: begin
          run_tick();
          return;
        end
        fcct_pkg::CMD_START_ONE, fcct_pkg::CMD_START_PER: begin
          add_due(counter,
                  start_channel(b.delay_ticks, b.command == fcct_pkg::CMD_START_PER),
                  '0, 1'b0, '0, 1'b1);
          return;
        end
        fcct_pkg::CMD_CHANGE: begin
          if (ok) compare_val[ch] = counter + b.delay_ticks;
        end
        fcct_pkg::CMD_STOP: begin
          if (ok) begin
            enabled[ch] = 1'b0;
            matched[ch] = 1'b0;
            pending[ch] = 1'b0;
            periodic[ch] = 1'b0;
            bypass[ch] = 1'b0;
          end
        end
        fcct_pkg::CMD_MARK_BYP: begin
          if (ok) bypass[ch] = 1'b1;
        end
        fcct_pkg::CMD_POLL: begin
          // One beat per pending channel, ascending; the last one is flagged.
          if (pending != '0) begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (pending[i]) begin
                pending[i] = 1'b0;
                add_due(counter, '0, '0, 1'b0, fcct_pkg::id_t'(i + 1), pending == '0);
              end
            end
            return;
          end
        end
        default: ;
      endcase
      add_due(counter, '0, '0, 1'b0, '0, 1'b1);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_beat(fcct_pkg::out_beat_t got);
      fcct_pkg::out_beat_t want;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result beat", got, 0);
        return;
      end
      want = due_results.pop_front();
      if (got.count_value != want.count_value)
        report_mismatch("count_value", got.count_value, want.count_value);
      if (got.assigned_id != want.assigned_id)
        report_mismatch("assigned_id", got.assigned_id, want.assigned_id);
      if (got.fired_channel != want.fired_channel)
        report_mismatch("fired_channel", got.fired_channel, want.fired_channel);
      if (got.bypass_event != want.bypass_event)
        report_mismatch("bypass_event", got.bypass_event, want.bypass_event);
      if (got.pending_channel != want.pending_channel)
        report_mismatch("pending_channel", got.pending_channel, want.pending_channel);
      if (got.last_result != want.last_result)
        report_mismatch("last_result", got.last_result, want.last_result);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  fcct_pkg::cnt_t cfg_data = '0;
  logic in_valid = 1'b0;
  fcct_pkg::in_beat_t in_beat = '0;
  logic in_stall;
  logic out_valid;
  fcct_pkg::out_beat_t out_beat;
  logic out_stall = 1'b0;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  timer_tracker tracker = new();

  four_channel_compare_timer_scheduler #(
    .CHANNELS(NUM_CH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_beat (out_beat),
    .out_stall(out_stall)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: checks each accepted beat and stalls at random or for a long hold.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_beat(out_beat);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Offer one beat, wait for it to be taken, then maybe leave a gap.
  task automatic send_beat(input fcct_pkg::in_beat_t b);
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_command(b);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic send_cmd(input fcct_pkg::cmd_t cmd, input fcct_pkg::id_t id,
                          input fcct_pkg::cnt_t delay);
    fcct_pkg::in_beat_t b;
    b.command = cmd;
    b.channel_id = id;
    b.delay_ticks = delay;
    send_beat(b);
  endtask

  // The divisor is only written once every due beat has come back.
  task automatic write_divisor(input fcct_pkg::cnt_t value);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_divisor(value);
  endtask

  // Mostly ticks and starts with short delays so that channels actually fire.
  function automatic fcct_pkg::in_beat_t random_beat();
    fcct_pkg::in_beat_t b;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) b.command = fcct_pkg::CMD_TICK;
    else if (pick < 57) b.command = fcct_pkg::CMD_START_ONE;
    else if (pick < 65) b.command = fcct_pkg::CMD_START_PER;
    else if (pick < 71) b.command = fcct_pkg::CMD_CHANGE;
    else if (pick < 77) b.command = fcct_pkg::CMD_STOP;
    else if (pick < 83) b.command = fcct_pkg::CMD_MARK_BYP;
    else if (pick < 95) b.command = fcct_pkg::CMD_POLL;
    else b.command = fcct_pkg::cmd_t'($urandom_range(7));
    if ($urandom_range(99) < 85) b.channel_id = fcct_pkg::id_t'($urandom_range(NUM_CH, 1));
    else b.channel_id = fcct_pkg::id_t'($urandom_range(7));
    if ($urandom_range(99) < 80) b.delay_ticks = fcct_pkg::cnt_t'($urandom_range(6));
    else b.delay_ticks = fcct_pkg::cnt_t'($urandom());
    return b;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_beat(random_beat());
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 23;
    recv_idle = 87;
    // Fill all four channels, then try one start too many.
    send_cmd(fcct_pkg::CMD_START_ONE, 3'd0, 16'd3);
    send_cmd(fcct_pkg::CMD_START_PER, 3'd0, 16'd2);
    send_cmd(fcct_pkg::CMD_START_ONE, 3'd0, 16'hFFFF);
    send_cmd(fcct_pkg::CMD_START_PER, 3'd0, 16'd5);
    send_cmd(fcct_pkg::CMD_START_ONE, 3'd0, 16'd1);
    send_cmd(fcct_pkg::CMD_MARK_BYP, 3'd2, 16'd0);
    send_cmd(fcct_pkg::CMD_MARK_BYP, 3'd0, 16'd0);
    // Periodic channel two fires twice around the one-shot on channel one.
    repeat (4) send_cmd(fcct_pkg::CMD_TICK, 3'd0, 16'd0);
    send_cmd(fcct_pkg::CMD_CHANGE, 3'd5, 16'd9);
    send_cmd(fcct_pkg::CMD_CHANGE, 3'd1, 16'd1);
    send_cmd(fcct_pkg::CMD_STOP, 3'd7, 16'd0);
    send_cmd(fcct_pkg::CMD_STOP, 3'd4, 16'd0);
    send_cmd(fcct_pkg::CMD_POLL, 3'd0, 16'd0);
    send_cmd(fcct_pkg::CMD_POLL, 3'd0, 16'd0);
    send_cmd(fcct_pkg::CMD_UNUSED, 3'd7, 16'hFFFF);
    // Two channels matching on the same tick are serviced one tick apart.
    send_cmd(fcct_pkg::CMD_START_ONE, 3'd0, 16'd2);
    send_cmd(fcct_pkg::CMD_CHANGE, 3'd2, 16'd2);
    repeat (3) send_cmd(fcct_pkg::CMD_TICK, 3'd0, 16'd0);
    send_cmd(fcct_pkg::CMD_POLL, 3'd0, 16'd0);

    write_divisor(16'hFFFF);
    run_random(20);
    // Dropping below the running prescale count advances on the next tick.
    write_divisor(16'd1);
    run_random(20);

    send_idle = 87;
    recv_idle = 23;
    write_divisor(16'd3);
    run_random(20);

    // No idling, with one long receiver hold so that the input backs up.
    send_idle = 0;
    recv_idle = 0;
    write_divisor(16'd0);
    hold_requests <= hold_requests + 1;
    run_random(20);

    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("four_channel_compare_timer_scheduler_tb OK");
    end else begin
      $display("four_channel_compare_timer_scheduler_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("four_channel_compare_timer_scheduler_tb NOT OK");
    $finish;
  end

endmodule
